[hdl/hki_pkg.sv]
// Shared types, codes and helpers of the keyframe interpolator.
// Used by every module of the block but hki_ram; depends on nothing.
package hki_pkg;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   localparam logic [1:0] ST_VIEW     = 2'd0;
   localparam logic [1:0] ST_ACCEPTED = 2'd1;
   localparam logic [1:0] ST_REJECTED = 2'd2;
   localparam logic [1:0] ST_FEW_KEYS = 2'd3;

   localparam logic CFG_TENSION = 1'b0;
   localparam logic CFG_BIAS    = 1'b1;

   localparam logic [2:0] CH_X     = 3'd0;
   localparam logic [2:0] CH_Y     = 3'd1;
   localparam logic [2:0] CH_Z     = 3'd2;
   localparam logic [2:0] CH_PITCH = 3'd3;
   localparam logic [2:0] CH_YAW   = 3'd4;
   localparam logic [2:0] CH_ROLL  = 3'd5;
   localparam logic [2:0] CH_FOV   = 3'd6;

   localparam int MIN_KEYS    = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int CHAN_W      = 33;
   localparam int MULA_W      = 37;
   localparam int MULB_W      = 33;
   localparam int PROD_W      = MULA_W + MULB_W;
   localparam int ACC_W       = 66;

   typedef struct packed {
      logic [23:0] frame;
      logic [31:0] time_stamp;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic [47:0] rotation;
      logic [15:0] fov;
   } key_type;

   typedef struct packed {
      logic        is_query;
      logic [1:0]  status;
      logic [23:0] frame;
      logic [31:0] time_stamp;
   } job_type;

   function automatic logic signed [CHAN_W-1:0] chan_value(input key_type k,
                                                           input logic [2:0] c);
      logic signed [CHAN_W-1:0] v;
      case (c)
         CH_X:     v = CHAN_W'($signed(k.pos_x));
         CH_Y:     v = CHAN_W'($signed(k.pos_y));
         CH_Z:     v = CHAN_W'($signed(k.pos_z));
         CH_PITCH: v = CHAN_W'($signed(k.rotation[15:0]));
         CH_YAW:   v = CHAN_W'($signed(k.rotation[31:16]));
         CH_ROLL:  v = CHAN_W'($signed(k.rotation[47:32]));
         default:  v = CHAN_W'($signed({1'b0, k.fov}));
      endcase
      return v;
   endfunction

endpackage

[hdl/hki_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the keyframe table.
module hki_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/hki_front.sv]
// Front end: accepts transactions, classifies them, appends keys and
// tracks the key count. Depends on hki_pkg.
module hki_front #(
   parameter int MAX_KEYS = 64,
   parameter int AW       = 6,
   parameter int CW       = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        operation,
   input  hki_pkg::key_type  req_key,
   input  logic              q_full,
   output logic              push,
   output hki_pkg::job_type  push_job,
   output logic              wr_en,
   output logic [AW-1:0]     wr_addr,
   output hki_pkg::key_type  wr_data,
   output logic [CW-1:0]     count,
   input  logic              done
);

   logic [CW-1:0] count_ff, count_in;
   logic [23:0]   last_ff, last_in;
   logic          pending_ff, pending_in;
   logic          accept;

   assign busy    = q_full | pending_ff;
   assign accept  = start & ~busy;
   assign wr_addr = count_ff[AW-1:0];
   assign wr_data = req_key;
   assign count   = count_ff;

   always_comb begin
      count_in            = count_ff;
      last_in             = last_ff;
      pending_in          = pending_ff & ~done;
      push                = 1'b0;
      wr_en               = 1'b0;
      push_job.is_query   = 1'b0;
      push_job.status     = hki_pkg::ST_REJECTED;
      push_job.frame      = req_key.frame;
      push_job.time_stamp = req_key.time_stamp;
      if (accept) begin
         push = 1'b1;
         case (operation)
            hki_pkg::OP_CLEAR: begin
               count_in        = '0;
               push_job.status = hki_pkg::ST_ACCEPTED;
            end
            hki_pkg::OP_APPEND: begin
               if (count_ff == CW'(MAX_KEYS) ||
                   (count_ff != '0 && req_key.frame <= last_ff)) begin
                  push_job.status = hki_pkg::ST_REJECTED;
               end else begin
                  wr_en           = 1'b1;
                  count_in        = count_ff + 1'b1;
                  last_in         = req_key.frame;
                  push_job.status = hki_pkg::ST_ACCEPTED;
               end
            end
            hki_pkg::OP_QUERY: begin
               if (count_ff < CW'(hki_pkg::MIN_KEYS)) begin
                  push_job.status = hki_pkg::ST_FEW_KEYS;
               end else begin
                  push_job.is_query = 1'b1;
                  push_job.status   = hki_pkg::ST_VIEW;
                  pending_in        = 1'b1;
               end
            end
            default: begin
               push_job.status = hki_pkg::ST_REJECTED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         pending_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_KEYS))
      else $error("key count above table size");

   a_query_blocks : assert property (@(posedge clock) disable iff (reset)
      (push && push_job.is_query) |=> (pending_ff && busy))
      else $error("query in flight does not hold off new transactions");

endmodule

[hdl/hki_queue.sv]
// Short in-order queue of classified transactions between front and back.
// Depends on hki_pkg.
module hki_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hki_pkg::job_type push_job,
   input  logic             pop,
   output hki_pkg::job_type head,
   output logic             full,
   output logic             empty
);

   localparam int PW = $clog2(hki_pkg::QUEUE_DEPTH);

   hki_pkg::job_type slot_ff [hki_pkg::QUEUE_DEPTH];
   logic [PW-1:0]    wp_ff, rp_ff;
   logic [PW:0]      fill_ff;

   assign full  = fill_ff == (PW+1)'(hki_pkg::QUEUE_DEPTH);
   assign empty = fill_ff == '0;
   assign head  = slot_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         fill_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (pop) begin
            rp_ff <= rp_ff + 1'b1;
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (pop && !push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= push_job;
      end
   end

endmodule

[hdl/hki_back.sv]
// Back end: key search, window load, time division and Hermite evaluation
// of seven channels on one shared multiplier. Depends on hki_pkg.
module hki_back #(
   parameter int AW = 6,
   parameter int CW = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  hki_pkg::job_type q_job,
   output logic             pop,
   input  logic [CW-1:0]    count,
   output logic [AW-1:0]    rd_addr,
   input  hki_pkg::key_type rd_data,
   input  logic [15:0]      tension,
   input  logic [15:0]      bias,
   output logic             done,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_x,
   output logic [31:0]      rsp_y,
   output logic [31:0]      rsp_z,
   output logic [15:0]      rsp_pitch,
   output logic [15:0]      rsp_yaw,
   output logic [15:0]      rsp_roll,
   output logic [15:0]      rsp_fov
);

   localparam int BW   = 52;
   localparam int AB_W = 26;
   localparam int MW   = 36;
   localparam int DW   = hki_pkg::CHAN_W + 1;
   localparam int ACC_W = hki_pkg::ACC_W;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SRCH_RD  = 4'd1;
   localparam logic [3:0] S_SRCH_CHK = 4'd2;
   localparam logic [3:0] S_WIN      = 4'd3;
   localparam logic [3:0] S_LOAD     = 4'd4;
   localparam logic [3:0] S_TSEL     = 4'd5;
   localparam logic [3:0] S_DIV      = 4'd6;
   localparam logic [3:0] S_BASIS    = 4'd7;
   localparam logic [3:0] S_CHAN     = 4'd8;

   localparam logic signed [BW-1:0]    ONE48   = $signed(BW'(1) << 48);
   localparam logic signed [BW-1:0]    RND_B   = $signed(BW'(1) << 23);
   localparam logic signed [ACC_W-1:0] RND_ACC = $signed(ACC_W'(1) << 23);
   localparam logic signed [15:0]      UNIT    = 16'sd16384;

   function automatic logic signed [AB_W-1:0] rnd_basis(input logic signed [BW-1:0] x);
      logic signed [BW-1:0] s;
      s = x + RND_B;
      return AB_W'(s >>> 24);
   endfunction

   function automatic logic [31:0] sat_chan(input logic signed [ACC_W-1:0] v,
                                            input logic [2:0] c);
      logic signed [ACC_W-1:0] hi, lo, r;
      if (c <= hki_pkg::CH_Z) begin
         hi = ACC_W'(32'sh7fffffff);
         lo = ~hi;
      end else if (c == hki_pkg::CH_FOV) begin
         hi = ACC_W'(17'sh0ffff);
         lo = '0;
      end else begin
         hi = ACC_W'(16'sh7fff);
         lo = ~hi;
      end
      r = (v > hi) ? hi : ((v < lo) ? lo : v);
      return r[31:0];
   endfunction

   function automatic logic signed [15:0] clamp_q14(input logic [15:0] v);
      logic signed [15:0] s;
      s = $signed(v);
      return (s > UNIT) ? UNIT : ((s < -UNIT) ? -UNIT : s);
   endfunction

   logic [3:0]               state_ff, state_in;
   hki_pkg::job_type         job_ff, job_in;
   logic [CW-1:0]            u_ff, u_in;
   logic [AW-1:0]            st_ff, st_in;
   logic [2:0]               k_ff, k_in;
   hki_pkg::key_type         ent_ff [4];
   hki_pkg::key_type         ent_in [4];
   logic [16:0]              t_ff, t_in;
   logic [32:0]              rem_ff, rem_in;
   logic [31:0]              den_ff, den_in;
   logic [3:0]               step_ff, step_in;
   logic [2:0]               c_ff, c_in;
   logic [33:0]              t2_ff, t2_in;
   logic signed [31:0]       fa_ff, fa_in, fb_ff, fb_in;
   logic signed [AB_W-1:0]   a_ff [4];
   logic signed [AB_W-1:0]   a_in [4];
   logic signed [MW-1:0]     m0_ff, m0_in, m1_ff, m1_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [hki_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [hki_pkg::MULA_W-1:0] mul_a;
   logic signed [hki_pkg::MULB_W-1:0] mul_b;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;
   logic [31:0]              rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;
   logic [15:0]              rsp_pitch_ff, rsp_pitch_in, rsp_yaw_ff, rsp_yaw_in;
   logic [15:0]              rsp_roll_ff, rsp_roll_in, rsp_fov_ff, rsp_fov_in;

   logic signed [hki_pkg::CHAN_W-1:0] y0, y1, y2, y3;
   logic signed [DW-1:0]     d01, d12, d23;
   logic signed [16:0]       tv, bv, one_p_bv, one_m_bv, one_m_tv;
   logic signed [BW-1:0]     t3s, t2w, t32w;
   logic signed [ACC_W-1:0]  prod_t, sum_acc, fin;
   logic [2:0]               back_n;
   logic [CW-1:0]            st_full;
   logic [31:0]              tc, tn, ts, chan_res;
   logic [32:0]              shifted;
   logic                     ge;

   assign y0 = hki_pkg::chan_value(ent_ff[0], c_ff);
   assign y1 = hki_pkg::chan_value(ent_ff[1], c_ff);
   assign y2 = hki_pkg::chan_value(ent_ff[2], c_ff);
   assign y3 = hki_pkg::chan_value(ent_ff[3], c_ff);
   assign d01 = DW'(y1) - DW'(y0);
   assign d12 = DW'(y2) - DW'(y1);
   assign d23 = DW'(y3) - DW'(y2);

   assign tv       = 17'(clamp_q14(tension));
   assign bv       = 17'(clamp_q14(bias));
   assign one_p_bv = 17'sd16384 + bv;
   assign one_m_bv = 17'sd16384 - bv;
   assign one_m_tv = 17'sd16384 - tv;

   assign t3s  = $signed(prod_ff[BW-1:0]);
   assign t2w  = $signed(BW'({t2_ff, 16'h0}));
   assign t32w = $signed(BW'({t_ff, 32'h0}));

   assign prod_t  = $signed(prod_ff[ACC_W-1:0]);
   assign sum_acc = acc_ff + prod_t;
   assign fin     = (sum_acc + RND_ACC) >>> 24;
   assign chan_res = sat_chan(fin, c_ff);

   assign back_n  = (u_ff == count) ? 3'd4 : ((u_ff == count - 1'b1) ? 3'd3 : 3'd2);
   assign st_full = (u_ff >= CW'(back_n)) ? u_ff - CW'(back_n) : '0;

   assign tc      = ent_ff[1].time_stamp;
   assign tn      = ent_ff[2].time_stamp;
   assign ts      = job_ff.time_stamp;
   assign shifted = {rem_ff[31:0], 1'b0};
   assign ge      = shifted >= {1'b0, den_ff};

   assign rd_addr = (state_ff == S_LOAD) ? st_ff + AW'(k_ff) : u_ff[AW-1:0];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == S_BASIS) begin
         case (step_ff)
            4'd0: begin
               mul_a = hki_pkg::MULA_W'($signed({1'b0, t_ff}));
               mul_b = hki_pkg::MULB_W'($signed({1'b0, t_ff}));
            end
            4'd1: begin
               mul_a = hki_pkg::MULA_W'($signed({1'b0, prod_ff[33:0]}));
               mul_b = hki_pkg::MULB_W'($signed({1'b0, t_ff}));
            end
            4'd2: begin
               mul_a = hki_pkg::MULA_W'(one_p_bv);
               mul_b = hki_pkg::MULB_W'(one_m_tv);
            end
            4'd3: begin
               mul_a = hki_pkg::MULA_W'(one_m_bv);
               mul_b = hki_pkg::MULB_W'(one_m_tv);
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end else if (state_ff == S_CHAN) begin
         case (step_ff)
            4'd0: begin
               mul_a = hki_pkg::MULA_W'(d01);
               mul_b = hki_pkg::MULB_W'(fa_ff);
            end
            4'd1: begin
               mul_a = hki_pkg::MULA_W'(d12);
               mul_b = hki_pkg::MULB_W'(fb_ff);
            end
            4'd2: begin
               mul_a = hki_pkg::MULA_W'(d12);
               mul_b = hki_pkg::MULB_W'(fa_ff);
            end
            4'd3: begin
               mul_a = hki_pkg::MULA_W'(d23);
               mul_b = hki_pkg::MULB_W'(fb_ff);
            end
            4'd4: begin
               mul_a = hki_pkg::MULA_W'(y1);
               mul_b = hki_pkg::MULB_W'(a_ff[0]);
            end
            4'd5: begin
               mul_a = hki_pkg::MULA_W'(m0_ff);
               mul_b = hki_pkg::MULB_W'(a_ff[1]);
            end
            4'd6: begin
               mul_a = hki_pkg::MULA_W'(m1_ff);
               mul_b = hki_pkg::MULB_W'(a_ff[2]);
            end
            4'd7: begin
               mul_a = hki_pkg::MULA_W'(y2);
               mul_b = hki_pkg::MULB_W'(a_ff[3]);
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end
   end

   assign prod_in = mul_a * mul_b;

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      u_in          = u_ff;
      st_in         = st_ff;
      k_in          = k_ff;
      ent_in        = ent_ff;
      t_in          = t_ff;
      rem_in        = rem_ff;
      den_in        = den_ff;
      step_in       = step_ff;
      c_in          = c_ff;
      t2_in         = t2_ff;
      fa_in         = fa_ff;
      fb_in         = fb_ff;
      a_in          = a_ff;
      m0_in         = m0_ff;
      m1_in         = m1_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_z_in      = rsp_z_ff;
      rsp_pitch_in  = rsp_pitch_ff;
      rsp_yaw_in    = rsp_yaw_ff;
      rsp_roll_in   = rsp_roll_ff;
      rsp_fov_in    = rsp_fov_ff;
      pop           = 1'b0;
      done          = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               pop = 1'b1;
               if (q_job.is_query) begin
                  job_in   = q_job;
                  u_in     = '0;
                  state_in = S_SRCH_RD;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = q_job.status;
                  rsp_x_in      = '0;
                  rsp_y_in      = '0;
                  rsp_z_in      = '0;
                  rsp_pitch_in  = '0;
                  rsp_yaw_in    = '0;
                  rsp_roll_in   = '0;
                  rsp_fov_in    = '0;
               end
            end
         end
         S_SRCH_RD: begin
            state_in = S_SRCH_CHK;
         end
         S_SRCH_CHK: begin
            if (rd_data.frame <= job_ff.frame) begin
               u_in = u_ff + 1'b1;
               state_in = (u_ff + 1'b1 == count) ? S_WIN : S_SRCH_RD;
            end else begin
               state_in = S_WIN;
            end
         end
         S_WIN: begin
            st_in    = st_full[AW-1:0];
            k_in     = '0;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (k_ff != '0) begin
               ent_in[2'(k_ff - 3'd1)] = rd_data;
            end
            k_in = k_ff + 1'b1;
            if (k_ff == 3'd4) begin
               state_in = S_TSEL;
            end
         end
         S_TSEL: begin
            step_in = '0;
            if (ts <= tc) begin
               t_in     = '0;
               state_in = S_BASIS;
            end else if (tn <= tc || (ts - tc) >= (tn - tc)) begin
               t_in     = 17'h10000;
               state_in = S_BASIS;
            end else begin
               t_in     = '0;
               rem_in   = {1'b0, ts - tc};
               den_in   = tn - tc;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in  = ge ? shifted - {1'b0, den_ff} : shifted;
            t_in    = {t_ff[15:0], ge};
            step_in = step_ff + 1'b1;
            if (step_ff == 4'd15) begin
               step_in  = '0;
               state_in = S_BASIS;
            end
         end
         S_BASIS: begin
            step_in = step_ff + 1'b1;
            case (step_ff)
               4'd1: begin
                  t2_in = prod_ff[33:0];
               end
               4'd2: begin
                  a_in[0] = rnd_basis((t3s <<< 1) - (t2w + (t2w <<< 1)) + ONE48);
                  a_in[1] = rnd_basis(t3s - (t2w <<< 1) + t32w);
                  a_in[2] = rnd_basis(t3s - t2w);
                  a_in[3] = rnd_basis((t2w + (t2w <<< 1)) - (t3s <<< 1));
               end
               4'd3: begin
                  fa_in = prod_ff[31:0];
               end
               4'd4: begin
                  fb_in    = prod_ff[31:0];
                  step_in  = '0;
                  c_in     = hki_pkg::CH_X;
                  state_in = S_CHAN;
               end
               default: begin
                  t2_in = t2_ff;
               end
            endcase
         end
         S_CHAN: begin
            step_in = step_ff + 1'b1;
            case (step_ff)
               4'd1, 4'd3, 4'd5: begin
                  acc_in = prod_t;
               end
               4'd2: begin
                  m0_in = MW'(sum_acc >>> 29);
               end
               4'd4: begin
                  m1_in = MW'(sum_acc >>> 29);
               end
               4'd6, 4'd7: begin
                  acc_in = sum_acc;
               end
               4'd8: begin
                  step_in = '0;
                  c_in    = c_ff + 1'b1;
                  case (c_ff)
                     hki_pkg::CH_X:     rsp_x_in     = chan_res;
                     hki_pkg::CH_Y:     rsp_y_in     = chan_res;
                     hki_pkg::CH_Z:     rsp_z_in     = chan_res;
                     hki_pkg::CH_PITCH: rsp_pitch_in = chan_res[15:0];
                     hki_pkg::CH_YAW:   rsp_yaw_in   = chan_res[15:0];
                     hki_pkg::CH_ROLL:  rsp_roll_in  = chan_res[15:0];
                     default:           rsp_fov_in   = chan_res[15:0];
                  endcase
                  if (c_ff == hki_pkg::CH_FOV) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = hki_pkg::ST_VIEW;
                     done          = 1'b1;
                     state_in      = S_IDLE;
                  end
               end
               default: begin
                  acc_in = acc_ff;
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      u_ff          <= u_in;
      st_ff         <= st_in;
      k_ff          <= k_in;
      ent_ff        <= ent_in;
      t_ff          <= t_in;
      rem_ff        <= rem_in;
      den_ff        <= den_in;
      step_ff       <= step_in;
      c_ff          <= c_in;
      t2_ff         <= t2_in;
      fa_ff         <= fa_in;
      fb_ff         <= fb_in;
      a_ff          <= a_in;
      m0_ff         <= m0_in;
      m1_ff         <= m1_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      rsp_status_ff <= rsp_status_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_z_ff      <= rsp_z_in;
      rsp_pitch_ff  <= rsp_pitch_in;
      rsp_yaw_ff    <= rsp_yaw_in;
      rsp_roll_ff   <= rsp_roll_in;
      rsp_fov_ff    <= rsp_fov_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_x      = rsp_x_ff;
   assign rsp_y      = rsp_y_ff;
   assign rsp_z      = rsp_z_ff;
   assign rsp_pitch  = rsp_pitch_ff;
   assign rsp_yaw    = rsp_yaw_ff;
   assign rsp_roll   = rsp_roll_ff;
   assign rsp_fov    = rsp_fov_ff;

   a_search_in_table : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRCH_CHK) |-> (u_ff < count))
      else $error("key search ran past the filled table");

   a_t_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BASIS) |-> (t_ff <= 17'h10000))
      else $error("interpolation parameter above one");

   a_view_source : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == hki_pkg::ST_VIEW) |-> ($past(state_ff) == S_CHAN))
      else $error("view result issued outside channel evaluation");

endmodule

[hdl/hermite_keyframe_interpolator_unit.sv]
// Top level of the keyframe interpolator: configuration registers, key RAM,
// front end, transaction queue and back end. Depends on hki_pkg and all hki_ modules.
//
// A transaction is taken at a rising edge with start high and busy low.
// Clear, append and rejected or short-table queries are settled by the front
// end at once; their one result passes through the queue and is registered in
// the back end, which drains one such transaction per cycle while no query is
// being evaluated, so they can follow back to back. A query on a table of n keys
// (n of four or more) runs a linear key search through the single read port of
// the key RAM up to u, the index of the first key past the query frame, then
// loads a four-key window, runs the time division when it is needed, and
// evaluates each of the seven channels on the one shared multiplier.
// While a query is in flight busy stays high. Each result is shown for one
// cycle with rsp_valid high and must be taken then; there is no back-pressure.
// The user must write tension and bias over the APB port only while the block is
// idle; the block does not enforce it. Reset empties the table and the queue and
// clears tension and bias; key RAM is not cleared and only used below the key count.
module hermite_keyframe_interpolator_unit #(
   parameter int MAX_KEYS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_operation,
   input  logic [23:0]        req_frame,
   input  logic [31:0]        req_time_stamp,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [15:0] req_pitch,
   input  logic signed [15:0] req_yaw,
   input  logic signed [15:0] req_roll,
   input  logic [15:0]        req_fov,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic signed [15:0] rsp_out_pitch,
   output logic signed [15:0] rsp_out_yaw,
   output logic signed [15:0] rsp_out_roll,
   output logic [15:0]        rsp_out_fov,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int AW = $clog2(MAX_KEYS);
   localparam int CW = $clog2(MAX_KEYS + 1);

   logic [15:0]      tension_ff, bias_ff;
   logic             csr_write;
   hki_pkg::key_type req_key, rd_data, wr_data;
   hki_pkg::job_type push_job, head;
   logic             push, pop, q_full, q_empty, wr_en, done;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [CW-1:0]    count;
   logic [31:0]      rsp_x, rsp_y, rsp_z;
   logic [15:0]      rsp_pitch, rsp_yaw, rsp_roll;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign prdata    = (paddr[2] == hki_pkg::CFG_BIAS) ? {16'h0, bias_ff}
                                                       : {16'h0, tension_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         tension_ff <= '0;
         bias_ff    <= '0;
      end else if (csr_write) begin
         if (paddr[2] == hki_pkg::CFG_TENSION) begin
            tension_ff <= pwdata[15:0];
         end else begin
            bias_ff <= pwdata[15:0];
         end
      end
   end

   assign req_key.frame      = req_frame;
   assign req_key.time_stamp = req_time_stamp;
   assign req_key.pos_x      = req_pos_x;
   assign req_key.pos_y      = req_pos_y;
   assign req_key.pos_z      = req_pos_z;
   assign req_key.rotation   = {req_roll, req_yaw, req_pitch};
   assign req_key.fov        = req_fov;

   hki_ram #(
      .WIDTH ($bits(hki_pkg::key_type)),
      .DEPTH (MAX_KEYS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   hki_front #(
      .MAX_KEYS (MAX_KEYS),
      .AW       (AW),
      .CW       (CW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .operation (req_operation),
      .req_key   (req_key),
      .q_full    (q_full),
      .push      (push),
      .push_job  (push_job),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .count     (count),
      .done      (done)
   );

   hki_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .full     (q_full),
      .empty    (q_empty)
   );

   hki_back #(
      .AW (AW),
      .CW (CW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_job      (head),
      .pop        (pop),
      .count      (count),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .tension    (tension_ff),
      .bias       (bias_ff),
      .done       (done),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status),
      .rsp_x      (rsp_x),
      .rsp_y      (rsp_y),
      .rsp_z      (rsp_z),
      .rsp_pitch  (rsp_pitch),
      .rsp_yaw    (rsp_yaw),
      .rsp_roll   (rsp_roll),
      .rsp_fov    (rsp_out_fov)
   );

   assign rsp_out_x     = $signed(rsp_x);
   assign rsp_out_y     = $signed(rsp_y);
   assign rsp_out_z     = $signed(rsp_z);
   assign rsp_out_pitch = $signed(rsp_pitch);
   assign rsp_out_yaw   = $signed(rsp_yaw);
   assign rsp_out_roll  = $signed(rsp_roll);

endmodule
